@@ src/compass_heading_circular_filter_macros.svh @@
// Assertion macros for the compass heading filter.
// Used by the top level only; no other dependencies.
`ifndef COMPASS_HEADING_CIRCULAR_FILTER_MACROS_SVH
`define COMPASS_HEADING_CIRCULAR_FILTER_MACROS_SVH
`ifndef SYNTH
`define CHF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHF_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHF_ASSERT(label, clk, rst_n, prop, msg)
`define CHF_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ src/chf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and tables of the compass heading filter.
// No dependencies.
package chf_pkg;
    localparam int Window = 8;
    localparam int SlotW = (Window > 1) ? $clog2(Window) : 1;
    localparam int CordicSteps = 16;
    localparam int StepW = 4;
    localparam int SumW = 22;
    localparam int CordW = 40;
    localparam logic [16:0] AlphaOne = 17'd65536;
    localparam logic signed [CordW-1:0] GainStart = 40'sd2547003;

    typedef struct packed {
        logic signed [11:0] mag_x;
        logic signed [11:0] mag_y;
        logic               sample_valid;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RAW, ST_OLD_SC, ST_OLD_ACC, ST_NEW_SC, ST_NEW_ACC,
        ST_MEAN, ST_DIFF, ST_MUL, ST_PROD, ST_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        OP_NONE, OP_ATAN, OP_SINCOS
    } cordic_op_t;

    function automatic logic [31:0] turn_atan(input logic [StepW-1:0] i);
        logic [31:0] v;
        begin
            case (i)
                4'd0: v = 32'd536870912;
                4'd1: v = 32'd316933406;
                4'd2: v = 32'd167458907;
                4'd3: v = 32'd85004756;
                4'd4: v = 32'd42667331;
                4'd5: v = 32'd21354465;
                4'd6: v = 32'd10679838;
                4'd7: v = 32'd5340245;
                4'd8: v = 32'd2670163;
                4'd9: v = 32'd1335087;
                4'd10: v = 32'd667544;
                4'd11: v = 32'd333772;
                4'd12: v = 32'd166886;
                4'd13: v = 32'd83443;
                4'd14: v = 32'd41722;
                default: v = 32'd20861;
            endcase
            return v;
        end
    endfunction
endpackage

@@ src/chf_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts samples and queues them for the back end.
// Depends on chf_pkg.
module chf_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  chf_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output chf_pkg::item_t q_item
);
    chf_pkg::item_t mem [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ src/chf_cordic.sv @@
`timescale 1ns / 1ps
// Iterative CORDIC: atan2 in vectoring mode, sin/cos in rotation mode.
// Depends on chf_pkg.
module chf_cordic
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  chf_pkg::cordic_op_t      op,
    input  logic signed [21:0]       in_y,
    input  logic signed [21:0]       in_x,
    input  logic [15:0]              in_angle,
    output logic                     done,
    output logic [15:0]              angle_out,
    output logic signed [15:0]       sin_out,
    output logic signed [15:0]       cos_out
);
    localparam int W = chf_pkg::CordW;
    logic signed [W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0]  z_reg, z_next;
    logic [chf_pkg::StepW-1:0] i_reg, i_next;
    logic busy_reg, busy_next, done_reg, done_next;
    chf_pkg::cordic_op_t op_reg, op_next;
    logic neg_reg, neg_next, zero_reg, zero_next;
    logic signed [W-1:0] dx, dy;
    logic signed [W-1:0] ex, ey;
    logic signed [33:0]  za, ta;
    logic dir;
    logic [31:0] zr;

    function automatic logic signed [15:0] rq(input logic signed [W-1:0] v, input logic n);
        logic signed [W-1:0] r;
        begin
            r = (v + W'(128)) >>> 8;
            if (r > W'(16384)) r = W'(16384);
            if (r < -W'(16384)) r = -W'(16384);
            if (n) r = -r;
            return r[15:0];
        end
    endfunction

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next = op_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        ex = W'(in_x);
        ey = W'(in_y);
        za = 34'(signed'({2'b00, in_angle, 16'h0000}));
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        ta = 34'(signed'({2'b00, chf_pkg::turn_atan(i_reg)}));
        if (op_reg == chf_pkg::OP_ATAN)
            dir = (y_reg >= 0);
        else
            dir = !(z_reg >= 0);
        if (start)
        begin
            op_next = op;
            busy_next = 1'b1;
            i_next = '0;
            if (op == chf_pkg::OP_ATAN)
            begin
                zero_next = (in_x == 0) && (in_y == 0);
                neg_next = 1'b0;
                if (in_x < 0)
                begin
                    ex = -ex;
                    ey = -ey;
                    z_next = 34'sh80000000;
                end
                else
                begin
                    z_next = '0;
                end
                x_next = ex <<< 10;
                y_next = ey <<< 10;
            end
            else
            begin
                zero_next = 1'b0;
                x_next = chf_pkg::GainStart;
                y_next = '0;
                if (in_angle[15]) za = za - 34'sh100000000;
                neg_next = 1'b0;
                if (za > 34'sh40000000)
                begin
                    za = za - 34'sh80000000;
                    neg_next = 1'b1;
                end
                else if (za < -34'sh40000000)
                begin
                    za = za + 34'sh80000000;
                    neg_next = 1'b1;
                end
                z_next = za;
            end
        end
        else if (busy_reg)
        begin
            if (dir)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ta;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ta;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == chf_pkg::StepW'(chf_pkg::CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign zr = z_reg[31:0] + 32'h8000;
    assign angle_out = zero_reg ? 16'd0 : zr[31:16];
    assign sin_out = rq(y_reg, neg_reg);
    assign cos_out = rq(x_reg, neg_reg);
    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
        op_reg <= op_next;
        neg_reg <= neg_next;
        zero_reg <= zero_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end
endmodule

@@ src/chf_back.sv @@
`timescale 1ns / 1ps
// Back end: ring, sums, circular mean and smoothing, one sample at a time.
// Depends on chf_pkg and chf_cordic.
module chf_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  chf_pkg::item_t q_item,
    input  logic [16:0]    alpha,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [15:0]    out_heading,
    output logic           out_updated
);
    chf_pkg::back_state_t st_reg, st_next;
    logic [15:0] ring [chf_pkg::Window];
    logic [chf_pkg::SlotW-1:0] slot_reg, slot_next;
    logic filled_reg, filled_next;
    logic signed [chf_pkg::SumW-1:0] ssum_reg, ssum_next, csum_reg, csum_next;
    logic [15:0] smooth_reg, smooth_next, raw_reg, raw_next;
    logic signed [16:0] d_reg, d_next;
    logic signed [34:0] prod_reg, prod_next;
    logic [15:0] ring_rd_reg;
    logic upd_reg, upd_next, ov_reg, ov_next;
    logic ring_we;
    logic c_start, c_done;
    chf_pkg::cordic_op_t c_op;
    logic signed [21:0] c_y, c_x;
    logic [15:0] c_ang, c_angle_out, diff;
    logic signed [15:0] c_sin, c_cos;
    logic [16:0] a_sat;
    logic signed [34:0] step;

    chf_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(c_start), .op(c_op),
        .in_y(c_y), .in_x(c_x), .in_angle(c_ang), .done(c_done),
        .angle_out(c_angle_out), .sin_out(c_sin), .cos_out(c_cos)
    );

    assign a_sat = (alpha > chf_pkg::AlphaOne) ? chf_pkg::AlphaOne : alpha;
    assign diff = raw_reg - smooth_reg;
    assign step = (prod_reg + 35'sd32768) >>> 16;
    assign q_ready = (st_reg == chf_pkg::ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_heading = smooth_reg;
    assign out_updated = upd_reg;

    always_comb
    begin
        st_next = st_reg;
        slot_next = slot_reg;
        filled_next = filled_reg;
        ssum_next = ssum_reg;
        csum_next = csum_reg;
        smooth_next = smooth_reg;
        raw_next = raw_reg;
        d_next = d_reg;
        prod_next = prod_reg;
        upd_next = upd_reg;
        ov_next = ov_reg;
        ring_we = 1'b0;
        c_start = 1'b0;
        c_op = chf_pkg::OP_NONE;
        c_y = 22'(q_item.mag_y);
        c_x = 22'(q_item.mag_x);
        c_ang = ring_rd_reg;
        if (ov_reg && out_ready) ov_next = 1'b0;
        unique case (st_reg)
            chf_pkg::ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    upd_next = q_item.sample_valid;
                    if (q_item.sample_valid)
                    begin
                        c_start = 1'b1;
                        c_op = chf_pkg::OP_ATAN;
                        st_next = chf_pkg::ST_RAW;
                    end
                    else
                    begin
                        ov_next = 1'b1;
                    end
                end
            end
            chf_pkg::ST_RAW:
            begin
                if (c_done)
                begin
                    raw_next = c_angle_out;
                    c_start = 1'b1;
                    if (filled_reg)
                    begin
                        c_op = chf_pkg::OP_SINCOS;
                        st_next = chf_pkg::ST_OLD_SC;
                    end
                    else
                    begin
                        c_op = chf_pkg::OP_SINCOS;
                        c_ang = c_angle_out;
                        st_next = chf_pkg::ST_NEW_SC;
                    end
                end
            end
            chf_pkg::ST_OLD_SC:
            begin
                if (c_done) st_next = chf_pkg::ST_OLD_ACC;
            end
            chf_pkg::ST_OLD_ACC:
            begin
                ssum_next = ssum_reg - chf_pkg::SumW'(c_sin);
                csum_next = csum_reg - chf_pkg::SumW'(c_cos);
                c_start = 1'b1;
                c_op = chf_pkg::OP_SINCOS;
                c_ang = raw_reg;
                st_next = chf_pkg::ST_NEW_SC;
            end
            chf_pkg::ST_NEW_SC:
            begin
                if (c_done) st_next = chf_pkg::ST_NEW_ACC;
            end
            chf_pkg::ST_NEW_ACC:
            begin
                ssum_next = ssum_reg + chf_pkg::SumW'(c_sin);
                csum_next = csum_reg + chf_pkg::SumW'(c_cos);
                ring_we = 1'b1;
                if (slot_reg == chf_pkg::SlotW'(chf_pkg::Window - 1))
                begin
                    slot_next = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                st_next = chf_pkg::ST_MEAN;
            end
            chf_pkg::ST_MEAN:
            begin
                c_start = 1'b1;
                c_op = chf_pkg::OP_ATAN;
                c_y = ssum_reg;
                c_x = csum_reg;
                st_next = chf_pkg::ST_DIFF;
            end
            chf_pkg::ST_DIFF:
            begin
                if (c_done)
                begin
                    raw_next = c_angle_out;
                    st_next = chf_pkg::ST_MUL;
                end
            end
            chf_pkg::ST_MUL:
            begin
                d_next = 17'(signed'(diff));
                st_next = chf_pkg::ST_PROD;
            end
            chf_pkg::ST_PROD:
            begin
                prod_next = signed'({1'b0, a_sat}) * d_reg;
                st_next = chf_pkg::ST_DONE;
            end
            chf_pkg::ST_DONE:
            begin
                smooth_next = smooth_reg + step[15:0];
                ov_next = 1'b1;
                st_next = chf_pkg::ST_IDLE;
            end
            default: st_next = chf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we) ring[slot_reg] <= raw_reg;
        ring_rd_reg <= ring[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        d_reg <= d_next;
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= chf_pkg::ST_IDLE;
            slot_reg <= '0;
            filled_reg <= 1'b0;
            ssum_reg <= '0;
            csum_reg <= '0;
            smooth_reg <= '0;
            upd_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            slot_reg <= slot_next;
            filled_reg <= filled_next;
            ssum_reg <= ssum_next;
            csum_reg <= csum_next;
            smooth_reg <= smooth_next;
            upd_reg <= upd_next;
            ov_reg <= ov_next;
        end
    end
endmodule

@@ src/compass_heading_circular_filter.sv @@
`timescale 1ns / 1ps
// Compass heading filter: windowed circular mean of atan2 headings, then smoothing.
// Work: a valid sample takes three 16-step CORDIC runs on one shared unit while the ring
// fills, four once it has wrapped; an invalid sample is answered without a CORDIC run.
// Throughput: one sample at a time; the next is taken from the queue only once the back
// end is idle again and the result of the last one has been taken.
// Reset: asynchronous, active low; clears sums, slot, fill flag, heading, alpha to 16384.
`include "compass_heading_circular_filter_macros.svh"
module compass_heading_circular_filter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // mag_x[11:0], mag_y[23:12]
    input  logic        s_axis_tuser,   // sample_valid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // heading[15:0]
    output logic        m_axis_tuser,   // updated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);
    logic [16:0] alpha_reg, alpha_next;
    chf_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;

    // pack the slave transaction into one item
    assign in_item = '{mag_x: s_axis_tdata[11:0], mag_y: s_axis_tdata[23:12],
                       sample_valid: s_axis_tuser};
    assign cfg_ready = 1'b1;

    always_comb
    begin
        alpha_next = alpha_reg;
        if (cfg_valid) alpha_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) alpha_reg <= 17'd16384;
        else alpha_reg <= alpha_next;
    end

    chf_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    chf_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .alpha(alpha_reg), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_heading(m_axis_tdata), .out_updated(m_axis_tuser)
    );

    // hold the result until taken
    `CHF_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
    // an invalid sample leaves the heading
    `CHF_ASSERT(a_inv, clk, rst_n, m_axis_tvalid && !m_axis_tuser |-> $stable(m_axis_tdata), "invalid sample moved heading")
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the compass heading filter: directed and random samples.
// Depends on chf_pkg and the compass_heading_circular_filter top level.

class heading_board;
    // filter copy
    logic [16:0] alpha_q;
    logic [15:0] ring_q [8];
    int          slot_q;
    bit          filled_q;
    logic signed [21:0] sin_acc;
    logic signed [21:0] cos_acc;
    logic [15:0] smooth_q;
    // pending expectations
    logic [15:0] heading_fifo [$];
    bit          updated_fifo [$];
    int          errors;

    function new();
        alpha_q = 17'd16384;
        slot_q = 0;
        filled_q = 0;
        sin_acc = '0;
        cos_acc = '0;
        smooth_q = '0;
        errors = 0;
    endfunction

    static function longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    static function logic [15:0] angle_of(longint y, longint x);
        logic [31:0] z;
        longint dx, dy;
        z = 32'd0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        x = x * 1024;
        y = y * 1024;
        for (int i = 0; i < 16; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += chf_pkg::turn_atan(i[3:0]);
            end
            else
            begin
                x -= dx; y += dy; z -= chf_pkg::turn_atan(i[3:0]);
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    static function longint to_q14(longint v, bit neg);
        longint r;
        r = fshift(v + 128, 8);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return neg ? -r : r;
    endfunction

    static function void sin_cos(logic [15:0] a, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit neg;
        z = longint'(a) * 65536;
        x = 2547003;
        y = 0;
        neg = 0;
        if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
        if (z > 64'sh4000_0000)
        begin
            z -= 64'sh8000_0000; neg = 1;
        end
        else if (z < -64'sh4000_0000)
        begin
            z += 64'sh8000_0000; neg = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(chf_pkg::turn_atan(i[3:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(chf_pkg::turn_atan(i[3:0]));
            end
        end
        s = to_q14(y, neg);
        c = to_q14(x, neg);
    endfunction

    // note an accepted sample and queue the heading it should produce
    function void note_sample(chf_pkg::item_t it);
        logic [15:0] raw, mean, diff;
        longint s, c, d, a, stp;
        if (it.sample_valid)
        begin
            raw = angle_of(longint'(it.mag_y), longint'(it.mag_x));
            if (filled_q)
            begin
                sin_cos(ring_q[slot_q], s, c);
                sin_acc -= 22'(s);
                cos_acc -= 22'(c);
            end
            ring_q[slot_q] = raw;
            sin_cos(raw, s, c);
            sin_acc += 22'(s);
            cos_acc += 22'(c);
            slot_q++;
            if (slot_q >= 8)
            begin
                slot_q = 0;
                filled_q = 1;
            end
            mean = angle_of(longint'(sin_acc), longint'(cos_acc));
            diff = mean - smooth_q;
            d = longint'($signed(diff));
            a = (alpha_q > 17'd65536) ? 65536 : longint'(alpha_q);
            stp = fshift(a * d + 32768, 16);
            smooth_q = smooth_q + stp[15:0];
        end
        heading_fifo.push_back(smooth_q);
        updated_fifo.push_back(it.sample_valid);
    endfunction

    function void check_result(logic [15:0] hd, logic upd);
        logic [15:0] eh;
        bit eu;
        if (heading_fifo.size() == 0)
        begin
            $error("unexpected result heading=%0d updated=%0d", hd, upd);
            errors++;
            return;
        end
        eh = heading_fifo.pop_front();
        eu = updated_fifo.pop_front();
        if (hd !== eh)
        begin
            $error("heading: expected %0d, actual %0d", eh, hd);
            errors++;
        end
        if (upd !== eu)
        begin
            $error("updated: expected %0d, actual %0d", eu, upd);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // mag_x[11:0], mag_y[23:12]
    logic        s_axis_tuser = 1'b0;   // sample_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // heading[15:0]
    logic        m_axis_tuser;          // updated
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;

    heading_board board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  samples_sent;
    int  results_seen;
    longint cycles;

    localparam longint CycleLimit = 64'd2_000_000;

    always #6 clk = ~clk;

    compass_heading_circular_filter DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Receiver: stall at random, check every result transaction on the edge it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_result(m_axis_tdata, m_axis_tuser);
                results_seen++;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: abandon the run if the block stops answering.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // Offer one sample and hold it until the block takes the transaction.
    task automatic send_sample(logic signed [11:0] x, logic signed [11:0] y, logic v);
        chf_pkg::item_t it;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        it.mag_x = x;
        it.mag_y = y;
        it.sample_valid = v;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= v;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_sample(it);
        samples_sent++;
    endtask

    // Drop the sender, drain all expected results, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.heading_fifo.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_alpha(logic [16:0] a);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.alpha_q = a;
    endtask

    // Random sample: mostly valid, a share of axis extremes and zeros.
    task automatic random_sample();
        logic signed [11:0] x, y;
        int pick;
        pick = $urandom_range(9);
        x = 12'($urandom);
        y = 12'($urandom);
        if (pick == 0) x = 12'sd0;
        if (pick == 1) y = 12'sd0;
        if (pick == 2)
        begin
            x = $urandom_range(1) ? 12'sh7FF : 12'sh800;
            y = $urandom_range(1) ? 12'sh7FF : 12'sh800;
        end
        send_sample(x, y, $urandom_range(99) < 85);
    endtask

    initial
    begin
        logic [16:0] alphas [6];
        board = new();
        cycles = 0;
        samples_sent = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        alphas = '{17'd65536, 17'd0, 17'd131071, 17'd1, 17'd30000, 17'd65535};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, axis extremes, invalid samples, half-turn swing.
        send_sample(12'sd0, 12'sd0, 1'b1);
        send_sample(12'sh7FF, 12'sd0, 1'b1);
        send_sample(12'sh800, 12'sd0, 1'b1);
        send_sample(12'sd0, 12'sh7FF, 1'b1);
        send_sample(12'sd0, 12'sh800, 1'b1);
        send_sample(12'sh800, 12'sh800, 1'b1);
        send_sample(12'sh7FF, 12'sh7FF, 1'b1);
        send_sample(12'sh123, 12'sh456, 1'b0);
        send_sample(12'sh800, 12'sh7FF, 1'b0);
        send_sample(12'sh7FF, 12'sh800, 1'b1);
        send_sample(-12'sd1, 12'sd0, 1'b1);
        // full alpha with a refilled window gives a half-turn difference
        write_alpha(17'd65536);
        repeat (8) send_sample(12'sd100, 12'sd0, 1'b1);
        repeat (8) send_sample(-12'sd100, 12'sd0, 1'b1);
        write_alpha(17'd131071);
        send_sample(12'sd5, 12'sd9, 1'b1);
        send_sample(12'sd0, 12'sd0, 1'b0);

        // Random phases across alpha settings and idling profiles.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_alpha(alphas[ph]);
            send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 57 : 0;
            recv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 31 : 0;
            repeat (270) random_sample();
        end
        send_idle_pct = 0;
        drain();

        $display("%0d samples sent, %0d results checked over six alpha settings",
                 samples_sent, results_seen);
        if (board.errors == 0 && board.heading_fifo.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
